>>> src/mq3_pkg.sv
// Shared types and constants for the median-of-three quicksort unit.
package mq3_pkg;

    localparam int unsigned VAL_W   = 32;
    localparam int unsigned TALLY_W = 16;
    localparam logic [TALLY_W-1:0] TALLY_MAX = '1;

    typedef struct packed {
        logic signed [VAL_W-1:0] value;
        logic                    last;
    } t_in_item;

    typedef struct packed {
        logic signed [VAL_W-1:0] sorted_value;
        logic                    final_res;
        logic [TALLY_W-1:0]      comparisons;
        logic [TALLY_W-1:0]      swaps;
    } t_out_item;

    typedef struct packed {
        logic [TALLY_W-1:0] cmp;
        logic [TALLY_W-1:0] swp;
    } t_tally;

    typedef struct packed {
        logic clr;
        logic inc_cmp;
        logic inc_swp;
    } t_tally_ctl;

endpackage

>>> src/mq3_tally.sv
// Saturating comparison and swap counters of one sort.
module mq3_tally (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  mq3_pkg::t_tally_ctl i_ctl,
    output mq3_pkg::t_tally     o_tally
);
    import mq3_pkg::*;

    t_tally r_tally;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctl.clr) begin
            r_tally <= '0;
        end else begin
            if (i_ctl.inc_cmp && r_tally.cmp != TALLY_MAX) begin
                r_tally.cmp <= r_tally.cmp + 1'b1;
            end
            if (i_ctl.inc_swp && r_tally.swp != TALLY_MAX) begin
                r_tally.swp <= r_tally.swp + 1'b1;
            end
        end
    end

    assign o_tally = r_tally;

endmodule

>>> src/mq3_stack.sv
// Stack of pending index ranges with a registered pop port.
module mq3_stack #(
    parameter int unsigned DEPTH = 64,
    parameter int unsigned AW    = 6
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  logic [AW-1:0] i_push_lo,
    input  logic [AW-1:0] i_push_hi,
    input  logic          i_pop,
    output logic [AW-1:0] o_lo,
    output logic [AW-1:0] o_hi,
    output logic          o_empty
);
    localparam int unsigned SW = $clog2(DEPTH + 1);
    localparam int unsigned PW = $clog2(DEPTH);

    logic [2*AW-1:0] r_mem [DEPTH];
    logic [2*AW-1:0] r_rd;
    logic [SW-1:0]   r_sp;
    logic [SW-1:0]   w_top;

    assign w_top = r_sp - 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sp <= '0;
        end else if (i_push && r_sp != SW'(DEPTH)) begin
            r_sp <= r_sp + 1'b1;
        end else if (i_pop && r_sp != '0) begin
            r_sp <= w_top;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push && r_sp != SW'(DEPTH)) begin
            r_mem[r_sp[PW-1:0]] <= {i_push_lo, i_push_hi};
        end
        r_rd <= r_mem[w_top[PW-1:0]];
    end

    assign o_lo    = r_rd[2*AW-1:AW];
    assign o_hi    = r_rd[AW-1:0];
    assign o_empty = (r_sp == '0);

endmodule

>>> src/median_of_three_quicksort_unit.sv
// Top level: load buffer, quicksort sequencer and sorted output.
//
// Items arrive on i_item and are taken at a rising edge with start high and
// busy low, one per cycle while loading. Each value goes into the buffer
// until MAX_ITEMS entries are held; further values are dropped. The item
// with last set starts an in-place median-of-three quicksort of the loaded
// set, driven by a small sequencer around one comparator and a buffer with
// one read and one write port, with an explicit stack of index ranges. busy
// stays high during the sort and the output phase.
// Results then leave on o_res, each marked by a one-cycle o_valid pulse,
// in ascending order; final_res marks the greatest. The receiver cannot
// stall, so results are never held.
// Every result carries the saturating tallies of its sort.
// A synchronous active-low reset empties the buffer, clears the tallies
// and returns the block to loading; no clearing pass is needed.
module median_of_three_quicksort_unit #(
    parameter int unsigned MAX_ITEMS = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    input  mq3_pkg::t_in_item  i_item,
    output logic               busy,
    output logic               o_valid,
    output mq3_pkg::t_out_item o_res
);
    import mq3_pkg::*;

    localparam int unsigned AW = $clog2(MAX_ITEMS);
    localparam int unsigned CW = AW + 1;

    localparam logic [4:0] ST_IDLE   = 5'd0;
    localparam logic [4:0] ST_SORT   = 5'd1;
    localparam logic [4:0] ST_POP    = 5'd2;
    localparam logic [4:0] ST_POP2   = 5'd3;
    localparam logic [4:0] ST_CS_RX  = 5'd4;
    localparam logic [4:0] ST_CS_RY  = 5'd5;
    localparam logic [4:0] ST_CS_CMP = 5'd6;
    localparam logic [4:0] ST_CS_WY  = 5'd7;
    localparam logic [4:0] ST_SI_RD  = 5'd8;
    localparam logic [4:0] ST_SI_CK  = 5'd9;
    localparam logic [4:0] ST_SJ_RD  = 5'd10;
    localparam logic [4:0] ST_SJ_CK  = 5'd11;
    localparam logic [4:0] ST_SX     = 5'd12;
    localparam logic [4:0] ST_SX2    = 5'd13;
    localparam logic [4:0] ST_FIN_RD = 5'd14;
    localparam logic [4:0] ST_FIN_W1 = 5'd15;
    localparam logic [4:0] ST_FIN_W2 = 5'd16;
    localparam logic [4:0] ST_PUSH1  = 5'd17;
    localparam logic [4:0] ST_PUSH2  = 5'd18;
    localparam logic [4:0] ST_EM_RD  = 5'd19;
    localparam logic [4:0] ST_EM_OUT = 5'd20;

    localparam logic [1:0] STEP_PIVOT = 2'd3;

    logic [4:0]       r_state, n_state;
    logic [CW-1:0]    r_count;
    logic [AW-1:0]    r_lo, r_hi, r_j;
    logic [CW-1:0]    r_i;
    logic [1:0]       r_step;
    logic [VAL_W-1:0] r_vx, r_vy, r_vi, r_vj, r_pivot, r_rd;
    logic [AW-1:0]    r_k;

    logic [VAL_W-1:0] r_mem [MAX_ITEMS];

    logic             mem_we;
    logic [AW-1:0]    mem_wa, mem_ra;
    logic [VAL_W-1:0] mem_wd;

    logic [AW-1:0]    w_mid, w_x, w_y;
    logic [VAL_W-1:0] cmp_a, cmp_b;
    logic             cmp_gt;
    logic             i_le_j, i_lt_j;
    logic             accept;

    logic             stk_push, stk_pop, stk_empty;
    logic [AW-1:0]    stk_push_lo, stk_push_hi, stk_lo, stk_hi;

    t_tally_ctl       tally_ctl;
    t_tally           tally;

    assign accept = start && !busy;
    assign busy   = (r_state != ST_IDLE);
    assign w_mid  = r_lo + ((r_hi - r_lo) >> 1);
    assign i_le_j = (r_i <= {1'b0, r_j});
    assign i_lt_j = (r_i < {1'b0, r_j});

    always_comb begin
        unique case (r_step)
            2'd0:    begin w_x = r_lo;  w_y = w_mid; end
            2'd1:    begin w_x = r_lo;  w_y = r_hi;  end
            2'd2:    begin w_x = w_mid; w_y = r_hi;  end
            default: begin w_x = r_lo;  w_y = w_mid; end
        endcase
    end

    // The single shared comparator.
    always_comb begin
        cmp_a = r_rd;
        cmp_b = r_pivot;
        if (r_state == ST_CS_CMP) begin
            cmp_a = r_vx;
            cmp_b = r_rd;
        end
        cmp_gt = $signed(cmp_a) > $signed(cmp_b);
    end

    mq3_stack #(
        .DEPTH (MAX_ITEMS),
        .AW    (AW)
    ) u_stack (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (stk_push),
        .i_push_lo (stk_push_lo),
        .i_push_hi (stk_push_hi),
        .i_pop     (stk_pop),
        .o_lo      (stk_lo),
        .o_hi      (stk_hi),
        .o_empty   (stk_empty)
    );

    mq3_tally u_tally (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (tally_ctl),
        .o_tally (tally)
    );

    always_comb begin
        n_state     = r_state;
        mem_we      = 1'b0;
        mem_wa      = w_x;
        mem_wd      = r_rd;
        mem_ra      = w_x;
        stk_push    = 1'b0;
        stk_push_lo = '0;
        stk_push_hi = r_count[AW-1:0] - 1'b1;
        stk_pop     = 1'b0;
        tally_ctl   = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    if (r_count != CW'(MAX_ITEMS)) begin
                        mem_we = 1'b1;
                        mem_wa = r_count[AW-1:0];
                        mem_wd = i_item.value;
                    end
                    if (i_item.last) begin
                        n_state = ST_SORT;
                    end
                end
            end
            ST_SORT: begin
                tally_ctl.clr = 1'b1;
                if (r_count > CW'(1)) begin
                    stk_push = 1'b1;
                    n_state  = ST_POP;
                end else begin
                    n_state = ST_EM_RD;
                end
            end
            ST_POP: begin
                if (stk_empty) begin
                    n_state = ST_EM_RD;
                end else begin
                    stk_pop = 1'b1;
                    n_state = ST_POP2;
                end
            end
            ST_POP2: n_state = ST_CS_RX;
            ST_CS_RX: begin
                mem_ra  = w_x;
                n_state = ST_CS_RY;
            end
            ST_CS_RY: begin
                mem_ra  = w_y;
                n_state = ST_CS_CMP;
            end
            ST_CS_CMP: begin
                if (r_step == STEP_PIVOT || cmp_gt) begin
                    mem_we            = 1'b1;
                    mem_wa            = w_x;
                    mem_wd            = r_rd;
                    tally_ctl.inc_swp = 1'b1;
                    tally_ctl.inc_cmp = (r_step != STEP_PIVOT);
                    n_state           = ST_CS_WY;
                end else begin
                    n_state = ST_CS_RX;
                end
            end
            ST_CS_WY: begin
                mem_we = 1'b1;
                mem_wa = w_y;
                mem_wd = r_vx;
                if (r_step == STEP_PIVOT) begin
                    n_state = ST_SI_RD;
                end else begin
                    n_state = ST_CS_RX;
                end
            end
            ST_SI_RD: begin
                mem_ra = r_i[AW-1:0];
                if (i_le_j) begin
                    n_state = ST_SI_CK;
                end else begin
                    n_state = ST_SJ_RD;
                end
            end
            ST_SI_CK: begin
                if (!cmp_gt) begin
                    tally_ctl.inc_cmp = 1'b1;
                    n_state           = ST_SI_RD;
                end else begin
                    n_state = ST_SJ_RD;
                end
            end
            ST_SJ_RD: begin
                mem_ra = r_j;
                if (i_le_j) begin
                    n_state = ST_SJ_CK;
                end else begin
                    n_state = ST_SX;
                end
            end
            ST_SJ_CK: begin
                if (cmp_gt) begin
                    tally_ctl.inc_cmp = 1'b1;
                    n_state           = ST_SJ_RD;
                end else begin
                    n_state = ST_SX;
                end
            end
            ST_SX: begin
                if (i_lt_j) begin
                    mem_we            = 1'b1;
                    mem_wa            = r_i[AW-1:0];
                    mem_wd            = r_vj;
                    tally_ctl.inc_swp = 1'b1;
                    n_state           = ST_SX2;
                end else begin
                    n_state = ST_FIN_RD;
                end
            end
            ST_SX2: begin
                mem_we  = 1'b1;
                mem_wa  = r_j;
                mem_wd  = r_vi;
                n_state = ST_SI_RD;
            end
            ST_FIN_RD: begin
                mem_ra  = r_j;
                n_state = ST_FIN_W1;
            end
            ST_FIN_W1: begin
                mem_we  = 1'b1;
                mem_wa  = r_lo;
                mem_wd  = r_rd;
                n_state = ST_FIN_W2;
            end
            ST_FIN_W2: begin
                mem_we            = 1'b1;
                mem_wa            = r_j;
                mem_wd            = r_pivot;
                tally_ctl.inc_swp = 1'b1;
                n_state           = ST_PUSH1;
            end
            ST_PUSH1: begin
                stk_push_lo = r_j + 1'b1;
                stk_push_hi = r_hi;
                stk_push    = ({1'b0, r_j} + 1'b1) < {1'b0, r_hi};
                n_state     = ST_PUSH2;
            end
            ST_PUSH2: begin
                stk_push_lo = r_lo;
                stk_push_hi = r_j - 1'b1;
                stk_push    = ({1'b0, r_lo} + CW'(2)) <= {1'b0, r_j};
                n_state     = ST_POP;
            end
            ST_EM_RD: begin
                mem_ra  = r_k;
                n_state = ST_EM_OUT;
            end
            ST_EM_OUT: begin
                if ({1'b0, r_k} + 1'b1 == r_count) begin
                    n_state = ST_IDLE;
                end else begin
                    n_state = ST_EM_RD;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
        r_rd <= r_mem[mem_ra];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_count <= '0;
            r_k     <= '0;
            o_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            o_valid <= (r_state == ST_EM_OUT);
            if (r_state == ST_IDLE && accept && r_count != CW'(MAX_ITEMS)) begin
                r_count <= r_count + 1'b1;
            end
            if (r_state == ST_EM_OUT) begin
                if (n_state == ST_IDLE) begin
                    r_count <= '0;
                    r_k     <= '0;
                end else begin
                    r_k <= r_k + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ST_POP2: begin
                r_lo   <= stk_lo;
                r_hi   <= stk_hi;
                r_step <= '0;
            end
            ST_CS_RY: r_vx <= r_rd;
            ST_CS_CMP: begin
                r_vy <= r_rd;
                if (!(r_step == STEP_PIVOT || cmp_gt)) begin
                    r_step <= r_step + 1'b1;
                end
            end
            ST_CS_WY: begin
                if (r_step == STEP_PIVOT) begin
                    r_pivot <= r_vy;
                    r_i     <= {1'b0, r_lo} + 1'b1;
                    r_j     <= r_hi;
                end else begin
                    r_step <= r_step + 1'b1;
                end
            end
            ST_SI_CK: begin
                r_vi <= r_rd;
                if (!cmp_gt) begin
                    r_i <= r_i + 1'b1;
                end
            end
            ST_SJ_CK: begin
                r_vj <= r_rd;
                if (cmp_gt) begin
                    r_j <= r_j - 1'b1;
                end
            end
            ST_EM_OUT: begin
                o_res.sorted_value <= r_rd;
                o_res.final_res    <= ({1'b0, r_k} + 1'b1 == r_count);
                o_res.comparisons  <= tally.cmp;
                o_res.swaps        <= tally.swp;
            end
            default: begin
            end
        endcase
    end

    a_final_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_res.final_res |=> !o_valid)
        else $error("result after the final item of a set");

    a_last_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && i_item.last |=> busy)
        else $error("last item did not start the sort");

    a_busy_mid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_res.final_res |-> busy)
        else $error("block idle before the final item was sent");

    a_no_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("results on back-to-back cycles");

endmodule
